FILE: rtl/core/mvsm_pkg.sv
// Shared widths, action codes and rounding helpers for the sample mixer.
package mvsm_pkg;

   localparam int VOICES       = 64;
   localparam int SAMPLE_WORDS = 65536;
   localparam int ASSETS       = 16;

   localparam int VOICE_W  = $clog2(VOICES);
   localparam int ADDR_W   = $clog2(SAMPLE_WORDS);
   localparam int ASSET_W  = 4;
   localparam int COUNT_W  = 7;
   localparam int MUL_A_W  = 28;
   localparam int MUL_B_W  = 16;
   localparam int PROD_W   = MUL_A_W + MUL_B_W + 1;
   localparam int SUM_W    = 28;
   localparam int POS_W    = 30;
   localparam int FRAC_W   = 14;
   localparam int ONE_Q14  = 16384;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [2:0] {
      ACT_LOAD_SAMPLE = 3'd0,
      ACT_LOAD_ASSET  = 3'd1,
      ACT_START       = 3'd2,
      ACT_STOP        = 3'd3,
      ACT_TICK        = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      CSR_MASTER = 2'd0,
      CSR_MUSIC  = 2'd1,
      CSR_EFFECT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] op_a;
      logic        [MUL_B_W-1:0] op_b;
   } mul_req_type;

   // add half an LSB, then floor
   function automatic logic signed [PROD_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] v, input int unsigned n);
      logic signed [PROD_W-1:0] half;
      half = $signed(PROD_W'(1) << (n - 1));
      return (v + half) >>> n;
   endfunction

   // {clip, value}
   function automatic logic [16:0] saturate16(input logic signed [PROD_W-1:0] v);
      logic [16:0] r;
      if (v > 45'sd32767) r = {1'b1, 16'h7FFF};
      else if (v < -45'sd32768) r = {1'b1, 16'h8000};
      else r = {1'b0, v[15:0]};
      return r;
   endfunction

endpackage

FILE: rtl/core/mvsm_mul_unit.sv
// Shared signed-by-unsigned multiplier with a registered product.
module mvsm_mul_unit
   import mvsm_pkg::*;
(
   input  logic                     clock,
   input  mul_req_type              req,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [MUL_B_W:0]  b_ext;

   assign b_ext = $signed({1'b0, req.op_b});

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(req.op_a * b_ext);
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/core/multi_voice_sample_mixer.sv
// Top level: sequencer, sample and voice memories, asset table and mix accumulators.
//
//   channel | ports  | beat contents
//   input   | req_*  | tuser action, tdata load/asset/voice fields
//   result  | rsp_*  | tdata mix frame, clip flag, active voice count
//   config  | csr_*  | register index and 16-bit write data
//
// Load and stop items finish on acceptance; a start scans voices for a free one.
// A tick visits each voice in turn and runs each active voice through the shared
// multiplier (8 products each), then scales the mix by the master gain and saturates it.
// Reset clears voices and asset lengths and sets gains to 4096; sample memory is not cleared.
// Input stays not ready until the item is done; a tick result waits for rsp_tready.
module multi_voice_sample_mixer
   import mvsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // sample_address, load_left, load_right, asset_id, asset_base, asset_frames,
   // asset_is_music, loop_flag, step, gain_left, gain_right, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [2:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // mix_left, mix_right, clipped, active_voices
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_START, S_SCAN, S_VOICE, S_SAMP_N, S_SAMP_W,
      S_M1, S_M2, S_M3, S_M4, S_M5, S_ADV, S_F1, S_F2, S_F3, S_OUT
   } state_type;

   state_type state_ff;

   logic [15:0] master_ff, music_ff, effect_ff;

   logic [15:0] ast_base_ff   [ASSETS];
   logic [15:0] ast_frames_ff [ASSETS];
   logic        ast_music_ff  [ASSETS];

   logic [31:0] samp_mem [SAMPLE_WORDS];
   logic [31:0] samp_rd_ff;
   logic [ADDR_W-1:0] samp_raddr;

   logic [POS_W-1:0] vpos_mem  [VOICES];
   logic [20:0]      vset_mem  [VOICES];
   logic [31:0]      vgain_mem [VOICES];
   logic [POS_W-1:0] vpos_rd_ff;
   logic [20:0]      vset_rd_ff;
   logic [31:0]      vgain_rd_ff;
   logic             vpos_we, vset_we;
   logic [POS_W-1:0] vpos_wd;

   logic [VOICES-1:0]  active_ff;
   logic [VOICE_W-1:0] v_ff;
   logic               v_last;

   logic [ASSET_W-1:0] st_id_ff;
   logic               st_loop_ff;
   logic [15:0]        st_step_ff, st_gl_ff, st_gr_ff;

   logic [POS_W-1:0]  pos_ff;
   logic [15:0]       frames_ff, nidx_ff;
   logic [15:0]       cur_base_ff;
   logic [15:0]       cg_ff;
   logic              ch_ff;
   logic [31:0]       cur_ff, nxt_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic signed [SUM_W-1:0]  sum_l_ff, sum_r_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [15:0]        out_l_ff;
   logic               clip_ff;
   logic [RSP_DATA_W-1:0] frame_ff;
   logic               rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   logic accept;
   logic [2:0] act;
   logic [ASSET_W-1:0] ast_raddr;
   logic [15:0] a_base, a_frames;
   logic        a_music;
   logic [15:0] idx_raw, idx_eff;
   logic [16:0] idx_p1;
   logic        past_end, restart;
   logic [15:0] nidx_eff;
   logic [POS_W:0] pos_sum;
   logic        adv_end;

   logic [15:0] cur_ch, nxt_ch, vgain_ch;
   logic [FRAC_W-1:0] frac;
   mul_req_type mreq;
   logic signed [PROD_W-1:0] prod, rnd14, rnd15, rnd12;
   logic [16:0] sat_v;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign act        = req_tuser;
   assign v_last     = (v_ff == VOICE_W'(VOICES - 1));

   assign ast_raddr = (state_ff == S_VOICE) ? vset_rd_ff[20:17] : st_id_ff;
   assign a_base    = ast_base_ff[ast_raddr];
   assign a_frames  = ast_frames_ff[ast_raddr];
   assign a_music   = ast_music_ff[ast_raddr];

   assign idx_raw  = vpos_rd_ff[POS_W-1:FRAC_W];
   assign past_end = (idx_raw >= a_frames);
   assign restart  = past_end && vset_rd_ff[16] && (a_frames != 16'd0);
   assign idx_eff  = restart ? 16'd0 : idx_raw;
   assign idx_p1   = {1'b0, idx_eff} + 17'd1;
   assign nidx_eff = (idx_p1 < {1'b0, a_frames}) ? idx_p1[15:0] : idx_eff;

   assign pos_sum = {1'b0, pos_ff} + (POS_W + 1)'(vset_rd_ff[15:0]);
   assign adv_end = (pos_sum[POS_W:FRAC_W] >= {1'b0, frames_ff});

   assign frac     = pos_ff[FRAC_W-1:0];
   assign cur_ch   = ch_ff ? cur_ff[15:0] : cur_ff[31:16];
   assign nxt_ch   = ch_ff ? nxt_ff[15:0] : nxt_ff[31:16];
   assign vgain_ch = ch_ff ? vgain_rd_ff[15:0] : vgain_rd_ff[31:16];

   assign rnd14 = round_shift(acc_ff + prod, 14);
   assign rnd15 = round_shift(prod, 15);
   assign rnd12 = round_shift(prod, 12);
   assign sat_v = saturate16(rnd12);

   always_comb begin
      mreq.op_a = '0;
      mreq.op_b = '0;
      case (state_ff)
         S_M1: begin
            mreq.op_a = MUL_A_W'($signed(cur_ch));
            mreq.op_b = MUL_B_W'(ONE_Q14) - MUL_B_W'(frac);
         end
         S_M2: begin
            mreq.op_a = MUL_A_W'($signed(nxt_ch));
            mreq.op_b = MUL_B_W'(frac);
         end
         S_M3: begin
            mreq.op_a = rnd14[MUL_A_W-1:0];
            mreq.op_b = vgain_ch;
         end
         S_M4: begin
            mreq.op_a = rnd15[MUL_A_W-1:0];
            mreq.op_b = cg_ff;
         end
         S_F1: begin
            mreq.op_a = sum_l_ff;
            mreq.op_b = master_ff;
         end
         S_F2: begin
            mreq.op_a = sum_r_ff;
            mreq.op_b = master_ff;
         end
         default: begin
            mreq.op_a = '0;
            mreq.op_b = '0;
         end
      endcase
   end

   mvsm_mul_unit u_mul (
      .clock (clock),
      .req   (mreq),
      .prod  (prod)
   );

   always_comb begin
      samp_raddr = nidx_ff[ADDR_W-1:0] + cur_base_ff[ADDR_W-1:0];
      if (state_ff == S_VOICE) samp_raddr = ADDR_W'(a_base + idx_eff);
   end

   always_ff @(posedge clock) begin
      if (accept && act == ACT_LOAD_SAMPLE) begin
         samp_mem[req_tdata[ADDR_W-1:0]] <= {req_tdata[31:16], req_tdata[47:32]};
      end
      samp_rd_ff <= samp_mem[samp_raddr];
   end

   always_comb begin
      vpos_we = 1'b0;
      vset_we = 1'b0;
      vpos_wd = '0;
      if (state_ff == S_START && a_frames != 16'd0 && !active_ff[v_ff]) begin
         vpos_we = 1'b1;
         vset_we = 1'b1;
      end else if (state_ff == S_ADV && !(adv_end && !vset_rd_ff[16])) begin
         vpos_we = 1'b1;
         vpos_wd = adv_end ? '0 : pos_sum[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (vpos_we) vpos_mem[v_ff] <= vpos_wd;
      if (vset_we) begin
         vset_mem[v_ff]  <= {st_id_ff, st_loop_ff, st_step_ff};
         vgain_mem[v_ff] <= {st_gl_ff, st_gr_ff};
      end
      vpos_rd_ff  <= vpos_mem[v_ff];
      vset_rd_ff  <= vset_mem[v_ff];
      vgain_rd_ff <= vgain_mem[v_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= 16'd4096;
         music_ff  <= 16'd4096;
         effect_ff <= 16'd4096;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MASTER: master_ff <= csr_wdata;
            CSR_MUSIC:  music_ff  <= csr_wdata;
            CSR_EFFECT: effect_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ASSETS; i++) begin
            ast_frames_ff[i] <= '0;
         end
      end else if (accept && act == ACT_LOAD_ASSET
                   && {1'b0, req_tdata[51:48]} < (ASSET_W + 1)'(ASSETS)) begin
         ast_frames_ff[req_tdata[51:48]] <= req_tdata[83:68];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && act == ACT_LOAD_ASSET) begin
         ast_base_ff[req_tdata[51:48]]  <= req_tdata[67:52];
         ast_music_ff[req_tdata[51:48]] <= req_tdata[84];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= '0;
         v_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_OUT) rsp_tvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  v_ff       <= '0;
                  st_id_ff   <= req_tdata[51:48];
                  st_loop_ff <= req_tdata[85];
                  st_step_ff <= req_tdata[101:86];
                  st_gl_ff   <= req_tdata[117:102];
                  st_gr_ff   <= req_tdata[133:118];
                  sum_l_ff   <= '0;
                  sum_r_ff   <= '0;
                  cnt_ff     <= '0;
                  case (act)
                     ACT_START: state_ff <= S_START;
                     ACT_STOP:  active_ff <= '0;
                     ACT_TICK:  state_ff <= S_SCAN;
                     default: ;
                  endcase
               end
            end
            S_START: begin
               if (a_frames == 16'd0) begin
                  state_ff <= S_IDLE;
               end else if (!active_ff[v_ff]) begin
                  active_ff[v_ff] <= 1'b1;
                  state_ff        <= S_IDLE;
               end else if (v_last) begin
                  state_ff <= S_IDLE;
               end else begin
                  v_ff <= v_ff + 1'b1;
               end
            end
            S_SCAN: begin
               if (active_ff[v_ff]) begin
                  state_ff <= S_VOICE;
               end else if (v_last) begin
                  state_ff <= S_F1;
               end else begin
                  v_ff <= v_ff + 1'b1;
               end
            end
            S_VOICE: begin
               if (past_end && !restart) begin
                  active_ff[v_ff] <= 1'b0;
                  if (v_last) state_ff <= S_F1;
                  else begin
                     v_ff     <= v_ff + 1'b1;
                     state_ff <= S_SCAN;
                  end
               end else begin
                  pos_ff      <= restart ? '0 : vpos_rd_ff;
                  frames_ff   <= a_frames;
                  nidx_ff     <= nidx_eff;
                  cur_base_ff <= a_base;
                  cg_ff       <= a_music ? music_ff : effect_ff;
                  ch_ff       <= 1'b0;
                  state_ff    <= S_SAMP_N;
               end
            end
            S_SAMP_N: begin
               cur_ff   <= samp_rd_ff;
               state_ff <= S_SAMP_W;
            end
            S_SAMP_W: begin
               nxt_ff   <= samp_rd_ff;
               state_ff <= S_M1;
            end
            S_M1: state_ff <= S_M2;
            S_M2: begin
               acc_ff   <= prod;
               state_ff <= S_M3;
            end
            S_M3: state_ff <= S_M4;
            S_M4: state_ff <= S_M5;
            S_M5: begin
               if (ch_ff) begin
                  sum_r_ff <= sum_r_ff + rnd12[SUM_W-1:0];
                  state_ff <= S_ADV;
               end else begin
                  sum_l_ff <= sum_l_ff + rnd12[SUM_W-1:0];
                  ch_ff    <= 1'b1;
                  state_ff <= S_M1;
               end
            end
            S_ADV: begin
               if (adv_end && !vset_rd_ff[16]) active_ff[v_ff] <= 1'b0;
               else cnt_ff <= cnt_ff + 1'b1;
               if (v_last) state_ff <= S_F1;
               else begin
                  v_ff     <= v_ff + 1'b1;
                  state_ff <= S_SCAN;
               end
            end
            S_F1: state_ff <= S_F2;
            S_F2: begin
               out_l_ff <= sat_v[15:0];
               clip_ff  <= sat_v[16];
               state_ff <= S_F3;
            end
            S_F3: begin
               frame_ff <= {cnt_ff, clip_ff | sat_v[16], sat_v[15:0], out_l_ff};
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff  <= frame_ff;
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:33] <= COUNT_W'(VOICES))
      else $error("active voice count out of range");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      accept && act == ACT_STOP |=> active_ff == '0)
      else $error("stop did not free all voices");

   a_voice_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_VOICE |-> active_ff[v_ff])
      else $error("mixing a free voice");

endmodule

FILE: test/mvsm_checker.sv
// Checker for the sample mixer: tracks mixer state, predicts tick frames, compares results.
`timescale 1ns / 1ps
module mvsm_checker
   import mvsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   output int                    pending,
   output int                    fail_count
);

   typedef struct packed {
      logic [6:0]  voices;
      logic        clip;
      logic [15:0] mix_r;
      logic [15:0] mix_l;
   } frame_type;

   logic [31:0] sample_mem [SAMPLE_WORDS];
   logic [15:0] base_tab [ASSETS];
   logic [15:0] frames_tab [ASSETS];
   logic        music_tab [ASSETS];
   logic        v_on [VOICES];
   int unsigned v_pos [VOICES];
   logic [3:0]  v_asset [VOICES];
   logic        v_loop [VOICES];
   logic [15:0] v_step [VOICES];
   logic [15:0] v_gl [VOICES];
   logic [15:0] v_gr [VOICES];
   logic [15:0] master_g, music_g, effect_g;
   frame_type   frame_q [$];

   assign pending = frame_q.size();

   function automatic longint rnd(input longint v, input int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint voice_out(input longint cur, input longint nxt, input longint frac,
                                        input logic [15:0] vg, input logic [15:0] cg);
      longint s;
      s = rnd(cur * (16384 - frac) + nxt * frac, 14);
      s = rnd(s * longint'(vg), 15);
      return rnd(s * longint'(cg), 12);
   endfunction

   function automatic logic [15:0] sat(input longint v, inout logic clip);
      if (v > 32767) begin
         clip = 1'b1;
         return 16'h7FFF;
      end
      if (v < -32768) begin
         clip = 1'b1;
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   task automatic mix_tick();
      longint sum_l, sum_r, frac;
      int unsigned pos, idx, nidx, frames;
      logic [3:0] a;
      logic [31:0] wc, wn;
      logic [15:0] cg;
      logic clip;
      int cnt;
      frame_type f;
      sum_l = 0;
      sum_r = 0;
      clip = 1'b0;
      cnt = 0;
      for (int i = 0; i < VOICES; i++) begin
         if (!v_on[i]) continue;
         a = v_asset[i];
         frames = frames_tab[a];
         pos = v_pos[i];
         idx = pos >> 14;
         if (idx >= frames) begin
            if (v_loop[i] && frames > 0) begin
               pos = 0;
               idx = 0;
            end else begin
               v_on[i] = 1'b0;
               continue;
            end
         end
         frac = pos & 16383;
         nidx = (idx + 1 < frames) ? idx + 1 : idx;
         wc = sample_mem[16'(base_tab[a] + idx)];
         wn = sample_mem[16'(base_tab[a] + nidx)];
         cg = music_tab[a] ? music_g : effect_g;
         sum_l += voice_out($signed(wc[31:16]), $signed(wn[31:16]), frac, v_gl[i], cg);
         sum_r += voice_out($signed(wc[15:0]), $signed(wn[15:0]), frac, v_gr[i], cg);
         pos += v_step[i];
         if ((pos >> 14) >= frames) begin
            if (v_loop[i]) pos = 0;
            else begin
               v_on[i] = 1'b0;
               continue;
            end
         end
         v_pos[i] = pos;
         cnt++;
      end
      f.mix_l = sat(rnd(sum_l * longint'(master_g), 12), clip);
      f.mix_r = sat(rnd(sum_r * longint'(master_g), 12), clip);
      f.clip = clip;
      f.voices = 7'(cnt);
      frame_q.push_back(f);
   endtask

   always @(posedge clock) begin
      frame_type got, exp_f;
      if (reset) begin
         for (int i = 0; i < ASSETS; i++) frames_tab[i] = '0;
         for (int i = 0; i < VOICES; i++) v_on[i] = 1'b0;
         master_g = 16'd4096;
         music_g = 16'd4096;
         effect_g = 16'd4096;
         frame_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MASTER: master_g = csr_wdata;
               CSR_MUSIC:  music_g = csr_wdata;
               CSR_EFFECT: effect_g = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (frame_q.size() == 0) begin
               $error("result beat with no frame expected");
               fail_count++;
            end else begin
               exp_f = frame_q.pop_front();
               if (got.mix_l != exp_f.mix_l) begin
                  $error("mix_left exp %0d got %0d", $signed(exp_f.mix_l), $signed(got.mix_l));
                  fail_count++;
               end
               if (got.mix_r != exp_f.mix_r) begin
                  $error("mix_right exp %0d got %0d", $signed(exp_f.mix_r), $signed(got.mix_r));
                  fail_count++;
               end
               if (got.clip != exp_f.clip) begin
                  $error("clipped exp %0d got %0d", exp_f.clip, got.clip);
                  fail_count++;
               end
               if (got.voices != exp_f.voices) begin
                  $error("active_voices exp %0d got %0d", exp_f.voices, got.voices);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               ACT_LOAD_SAMPLE:
                  sample_mem[req_tdata[15:0]] = {req_tdata[31:16], req_tdata[47:32]};
               ACT_LOAD_ASSET: begin
                  base_tab[req_tdata[51:48]] = req_tdata[67:52];
                  frames_tab[req_tdata[51:48]] = req_tdata[83:68];
                  music_tab[req_tdata[51:48]] = req_tdata[84];
               end
               ACT_START: begin
                  if (frames_tab[req_tdata[51:48]] != 0) begin
                     for (int i = 0; i < VOICES; i++) begin
                        if (!v_on[i]) begin
                           v_on[i] = 1'b1;
                           v_pos[i] = 0;
                           v_asset[i] = req_tdata[51:48];
                           v_loop[i] = req_tdata[85];
                           v_step[i] = req_tdata[101:86];
                           v_gl[i] = req_tdata[117:102];
                           v_gr[i] = req_tdata[133:118];
                           break;
                        end
                     end
                  end
               end
               ACT_STOP: for (int i = 0; i < VOICES; i++) v_on[i] = 1'b0;
               ACT_TICK: mix_tick();
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: test/tb.sv
// Testbench top for the sample mixer: clock, reset, stimulus, register phases and verdict.
`timescale 1ns / 1ps
module tb;
   import mvsm_pkg::*;

   localparam int WIN_BASE = 65520;
   localparam int WIN_LEN  = 64;

   typedef struct {
      logic [2:0]  act;
      logic [15:0] addr, left, right;
      logic [3:0]  id;
      logic [15:0] base, frames;
      logic        music, loop_on;
      logic [15:0] step, gl, gr;
   } mix_cmd_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [2:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [1:0]            csr_index;
   logic [15:0]           csr_wdata;
   int                    pending;
   int                    fail_count;
   int                    send_idle_pct;
   int                    rsp_stall_pct;
   longint                cycles = 0;

   multi_voice_sample_mixer u_dut (.*);

   mvsm_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 6000000) begin
         $display("FAIL multi_voice_sample_mixer");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   task automatic send(input mix_cmd_type c);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= c.act;
      req_tdata <= {2'b00, c.gr, c.gl, c.step, c.loop_on, c.music, c.frames, c.base, c.id,
                    c.right, c.left, c.addr};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic mix_cmd_type rand_cmd(input logic [2:0] act);
      mix_cmd_type c;
      int off;
      c.act = act;
      c.addr = 16'($urandom());
      c.left = 16'($urandom());
      c.right = 16'($urandom());
      c.id = 4'($urandom());
      off = $urandom_range(0, WIN_LEN - 1);
      c.base = 16'(WIN_BASE + off);
      c.frames = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, WIN_LEN - off));
      c.music = 1'($urandom());
      c.loop_on = ($urandom_range(0, 2) != 0);
      c.step = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 20000));
      c.gl = 16'($urandom_range(0, 32768));
      c.gr = 16'($urandom_range(0, 32768));
      if (act == ACT_LOAD_SAMPLE && $urandom_range(0, 1))
         c.addr = 16'(WIN_BASE + $urandom_range(0, WIN_LEN - 1));
      return c;
   endfunction

   task automatic wr_csr(input csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   initial begin
      mix_cmd_type c;
      int r;
      logic [15:0] g [3];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_TICK;
      csr_we = 1'b0;
      csr_index = CSR_MASTER;
      csr_wdata = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the sample window every playable asset lives in
      for (int i = 0; i < WIN_LEN; i++) begin
         c = rand_cmd(ACT_LOAD_SAMPLE);
         c.addr = 16'(WIN_BASE + i);
         if (i < 4) begin
            c.left = (i % 2) ? 16'h8000 : 16'h7FFF;
            c.right = (i % 2) ? 16'h7FFF : 16'h8000;
         end
         send(c);
      end

      // directed
      c = rand_cmd(ACT_LOAD_ASSET); c.id = 4'd0; c.base = 16'(WIN_BASE); c.frames = 16'd64;
      c.music = 1'b1;
      send(c);
      c = rand_cmd(ACT_LOAD_ASSET); c.id = 4'd15; c.base = 16'hFFFF; c.frames = 16'd1;
      c.music = 1'b0;
      send(c);
      c = rand_cmd(ACT_LOAD_ASSET); c.id = 4'd3; c.frames = 16'd0; send(c);
      c = rand_cmd(ACT_START); c.id = 4'd3; send(c);
      c = rand_cmd(ACT_START); c.id = 4'd0; c.loop_on = 1'b1; c.step = 16'hFFFF;
      c.gl = 16'd32768; c.gr = 16'd32768; send(c);
      c = rand_cmd(ACT_START); c.id = 4'd15; c.loop_on = 1'b0; c.step = 16'd0; c.gl = 16'd0;
      c.gr = 16'd32768;
      send(c);
      c = rand_cmd(ACT_START); c.id = 4'd0; c.loop_on = 1'b0; c.step = 16'd8192; send(c);
      repeat (3) send(rand_cmd(ACT_TICK));
      send(rand_cmd(3'd7));
      send(rand_cmd(3'd5));
      c = rand_cmd(ACT_LOAD_ASSET); c.id = 4'd0; c.frames = 16'd2; c.base = 16'(WIN_BASE);
      send(c);
      send(rand_cmd(ACT_TICK));
      send(rand_cmd(ACT_STOP));
      send(rand_cmd(ACT_TICK));
      c = rand_cmd(ACT_LOAD_ASSET); c.id = 4'd5; c.frames = 16'hFFFF; c.base = 16'h0000;
      send(c);
      c = rand_cmd(ACT_LOAD_ASSET); c.id = 4'd5; c.frames = 16'h0000; c.base = 16'hFFFF;
      send(c);
      c = rand_cmd(ACT_LOAD_SAMPLE); c.addr = 16'hFFFF; c.left = 16'h8000; c.right = 16'h7FFF;
      send(c);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin g[0] = 16'd4096; g[1] = 16'd4096; g[2] = 16'd4096; end
            1: begin g[0] = 16'hFFFF; g[1] = 16'hFFFF; g[2] = 16'hFFFF; end
            2: begin g[0] = 16'd0; g[1] = 16'hFFFF; g[2] = 16'd0; end
            3: begin g[0] = 16'hFFFF; g[1] = 16'd0; g[2] = 16'h2000; end
            default: begin
               g[0] = 16'($urandom());
               g[1] = 16'($urandom());
               g[2] = 16'($urandom());
            end
         endcase
         wr_csr(CSR_MASTER, g[0]);
         wr_csr(CSR_MUSIC, g[1]);
         wr_csr(CSR_EFFECT, g[2]);
         wr_csr(csr_index_type'(2'd3), 16'($urandom()));
         case (ph)
            1: begin send_idle_pct = 79; rsp_stall_pct = 0; end
            2: begin send_idle_pct = 0; rsp_stall_pct = 79; end
            3: begin send_idle_pct = 29; rsp_stall_pct = 29; end
            default: begin send_idle_pct = 0; rsp_stall_pct = 0; end
         endcase
         for (int n = 0; n < 240; n++) begin
            r = $urandom_range(0, 99);
            if (r < 38) send(rand_cmd(ACT_TICK));
            else if (r < 70) send(rand_cmd(ACT_START));
            else if (r < 82) send(rand_cmd(ACT_LOAD_ASSET));
            else if (r < 94) send(rand_cmd(ACT_LOAD_SAMPLE));
            else if (r < 97) send(rand_cmd(ACT_STOP));
            else send(rand_cmd(3'($urandom_range(5, 7))));
         end
         drain();
      end

      if (fail_count == 0)
         $display("PASS multi_voice_sample_mixer");
      else
         $display("FAIL multi_voice_sample_mixer");
      $finish;
   end

endmodule
